// ===== hdl/sct_pkg.sv =====
// package: types, codes and character classes for the source tokenizer
`timescale 1ns / 1ps
package sct_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int MAX_RES = 6;
	localparam int CNT_BITS = 3;

	// lexer states
	localparam logic [3:0] ST_NORMAL  = 4'd0;
	localparam logic [3:0] ST_COMMENT = 4'd1;
	localparam logic [3:0] ST_NAME    = 4'd2;
	localparam logic [3:0] ST_RADIX   = 4'd3;
	localparam logic [3:0] ST_BIN     = 4'd4;
	localparam logic [3:0] ST_OCT     = 4'd5;
	localparam logic [3:0] ST_DEC     = 4'd6;
	localparam logic [3:0] ST_HEX     = 4'd7;
	localparam logic [3:0] ST_CHAR    = 4'd8;
	localparam logic [3:0] ST_STRING  = 4'd9;
	localparam logic [3:0] ST_OPER    = 4'd10;

	// token kinds
	localparam logic [3:0] K_OTHER  = 4'd0;
	localparam logic [3:0] K_STRING = 4'd1;
	localparam logic [3:0] K_CHAR   = 4'd2;
	localparam logic [3:0] K_DEC    = 4'd3;
	localparam logic [3:0] K_FLOAT  = 4'd4;
	localparam logic [3:0] K_BIN    = 4'd5;
	localparam logic [3:0] K_OCT    = 4'd6;
	localparam logic [3:0] K_HEX    = 4'd7;
	localparam logic [3:0] K_NAME   = 4'd8;
	localparam logic [3:0] K_OPER   = 4'd9;
	localparam logic [3:0] K_EOF    = 4'd10;
	localparam logic [3:0] K_ERROR  = 4'd11;

	// escape phases
	localparam logic [2:0] ESC_NONE  = 3'd0;
	localparam logic [2:0] ESC_FIRST = 3'd1;
	localparam logic [2:0] ESC_HEX1  = 3'd2;
	localparam logic [2:0] ESC_HEX2  = 3'd3;
	localparam logic [2:0] ESC_OCT2  = 3'd4;
	localparam logic [2:0] ESC_OCT3  = 3'd5;

	localparam logic [0:0] IK_VALUE = 1'b0;
	localparam logic [0:0] IK_END   = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  value_byte;
		logic [3:0]  token_kind;
		logic [15:0] token_row;
		logic [15:0] token_column;
		logic        last_of_run;
	} out_word_t;

	// one run of results from one input word
	typedef struct packed {
		logic [CNT_BITS-1:0] count;
		out_word_t [MAX_RES-1:0] res;
	} run_t;

	function automatic logic is_dig(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_odig(input logic [7:0] c);
		return c inside {[8'h30:8'h37]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dig(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h0;
		if (is_dig(c)) t = c - 8'h30;
		else if (c inside {[8'h61:8'h66]}) t = c - 8'h57;
		else t = c - 8'h37;
		return t[3:0];
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c inside {"+", "-", "*", "/", "%", "&", "|", "^", "=", "<", ">", "!", "~"};
	endfunction

	function automatic logic is_cop(input logic [7:0] c);
		return c inside {"+", "-", "&", "|", "^", "=", "<", ">"};
	endfunction

endpackage

// ===== hdl/sct_front.sv =====
// front: lexer state machine, turns one input word into a run of results
`timescale 1ns / 1ps
module sct_front import sct_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     run_valid,
	input  logic     run_ready,
	output run_t     run_data
);

	localparam logic [POSITION_BITS-1:0] PMAX = '1;

	logic [3:0] lex_state_q;
	logic float_seen_q, dot_pending_q, esc_stop_q;
	logic [2:0] escape_phase_q;
	logic [8:0] escape_accum_q;
	logic [POSITION_BITS-1:0] cur_row_q, cur_column_q, start_row_q, start_column_q;

	logic [3:0] n_state;
	logic n_float, n_dot, n_stop;
	logic [2:0] n_phase;
	logic [8:0] n_accum;
	logic [POSITION_BITS-1:0] n_row, n_col, n_srow, n_scol;
	run_t run;

	logic run_valid_q;
	run_t run_q;

	function automatic logic [15:0] clip(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
		return (v == PMAX) ? v : v + 1'b1;
	endfunction

	// one input word worth of lexing
	always_comb begin
		logic [7:0] b;
		logic relex, stop_dig;
		logic [3:0] dv;
		logic [8:0] acc;
		b = in_data.in_byte;
		relex = 1'b0;
		stop_dig = 1'b0;
		dv = 4'h0;
		acc = 9'h0;
		n_state = lex_state_q;
		n_float = float_seen_q;
		n_dot = dot_pending_q;
		n_stop = esc_stop_q;
		n_phase = escape_phase_q;
		n_accum = escape_accum_q;
		n_row = cur_row_q;
		n_col = sat_inc(cur_column_q);
		n_srow = start_row_q;
		n_scol = start_column_q;
		run = '0;

		if (in_data.end_of_input) begin
			if (dot_pending_q) begin
				run.res[run.count] = '{IK_END, 8'h0, K_OTHER, clip(start_row_q),
					clip(start_column_q), 1'b0};
				run.count = run.count + 1'b1;
			end else begin
				case (lex_state_q)
					ST_COMMENT, ST_STRING, ST_CHAR: begin
						run.res[run.count] = '{IK_END, 8'h0, K_ERROR, clip(start_row_q),
							clip(start_column_q), 1'b0};
						run.count = run.count + 1'b1;
					end
					ST_RADIX: begin
						run.res[0] = '{IK_VALUE, "0", K_OTHER, 16'h0, 16'h0, 1'b0};
						run.res[1] = '{IK_END, 8'h0, K_DEC, clip(start_row_q),
							clip(start_column_q), 1'b0};
						run.count = 3'd2;
					end
					ST_BIN, ST_OCT, ST_HEX, ST_DEC, ST_NAME, ST_OPER: begin
						run.res[0] = '{IK_END, 8'h0,
							(lex_state_q == ST_BIN) ? K_BIN :
							(lex_state_q == ST_OCT) ? K_OCT :
							(lex_state_q == ST_HEX) ? K_HEX :
							(lex_state_q == ST_NAME) ? K_NAME :
							(lex_state_q == ST_OPER) ? K_OPER :
							(float_seen_q ? K_FLOAT : K_DEC),
							clip(start_row_q), clip(start_column_q), 1'b0};
						run.count = 3'd1;
					end
					default: ;
				endcase
			end
			n_dot = 1'b0;
			n_state = ST_NORMAL;
			n_phase = ESC_NONE;
			n_accum = 9'h0;
			n_stop = 1'b0;
			run.res[run.count] = '{IK_END, 8'h0, K_EOF, clip(cur_row_q), clip(n_col), 1'b0};
			run.count = run.count + 1'b1;
		end else if (dot_pending_q) begin
			n_dot = 1'b0;
			if (is_dig(b)) begin
				n_state = ST_DEC;
				n_float = 1'b1;
				run.res[0] = '{IK_VALUE, b, K_OTHER, 16'h0, 16'h0, 1'b0};
				run.count = 3'd1;
			end else begin
				run.res[0] = '{IK_END, 8'h0, K_OTHER, clip(start_row_q),
					clip(start_column_q), 1'b0};
				run.count = 3'd1;
				relex = 1'b1;
			end
		end else begin
			case (lex_state_q)
				ST_COMMENT: begin
					if (b == "#") n_state = ST_NORMAL;
					else if (b == 8'h0A) begin
						n_col = '0;
						n_row = sat_inc(cur_row_q);
					end
				end
				ST_STRING, ST_CHAR: begin
					if (escape_phase_q != ESC_NONE) begin
						case (escape_phase_q)
							ESC_FIRST: begin
								n_accum = 9'h0;
								n_stop = 1'b0;
								n_phase = ESC_NONE;
								run.count = 3'd1;
								case (b)
									"a": run.res[0].value_byte = 8'h07;
									"b": run.res[0].value_byte = 8'h08;
									"t": run.res[0].value_byte = 8'h09;
									"n": run.res[0].value_byte = 8'h0A;
									"v": run.res[0].value_byte = 8'h0B;
									"f": run.res[0].value_byte = 8'h0C;
									"r": run.res[0].value_byte = 8'h0D;
									"x": begin
										n_phase = ESC_HEX1;
										run.count = 3'd0;
									end
									default: begin
										if (is_odig(b)) begin
											n_accum = {6'h0, b[2:0]};
											n_phase = ESC_OCT2;
											run.count = 3'd0;
										end else begin
											run.res[0].value_byte = b;
										end
									end
								endcase
							end
							default: begin
								// digit step of a hex or octal escape
								if (escape_phase_q == ESC_HEX1 || escape_phase_q == ESC_HEX2) begin
									stop_dig = !is_hex(b);
									dv = hex_val(b);
									acc = {escape_accum_q[4:0], dv};
								end else begin
									stop_dig = !is_odig(b);
									dv = {1'b0, b[2:0]};
									acc = {escape_accum_q[5:0], dv[2:0]};
								end
								if (!esc_stop_q) begin
									if (stop_dig) n_stop = 1'b1;
									else n_accum = acc;
								end
								if (escape_phase_q == ESC_HEX1) n_phase = ESC_HEX2;
								else if (escape_phase_q == ESC_OCT2) n_phase = ESC_OCT3;
								else begin
									n_phase = ESC_NONE;
									run.res[0].value_byte = n_accum[7:0];
									run.count = 3'd1;
								end
							end
						endcase
					end else if (b == ((lex_state_q == ST_STRING) ? 8'h22 : 8'h27)) begin
						run.res[0] = '{IK_END, 8'h0,
							(lex_state_q == ST_STRING) ? K_STRING : K_CHAR,
							clip(start_row_q), clip(start_column_q), 1'b0};
						run.count = 3'd1;
						n_state = ST_NORMAL;
					end else if (b == 8'h5C) begin
						n_phase = ESC_FIRST;
					end else begin
						run.res[0].value_byte = b;
						run.count = 3'd1;
					end
				end
				ST_RADIX: begin
					if (b == "b" || b == "B") n_state = ST_BIN;
					else if (b == "x" || b == "X") n_state = ST_HEX;
					else if (b == ".") begin
						n_state = ST_DEC;
						n_float = 1'b1;
						run.res[0].value_byte = "0";
						run.res[1].value_byte = ".";
						run.count = 3'd2;
					end else if (is_odig(b)) begin
						n_state = ST_OCT;
						run.res[0].value_byte = b;
						run.count = 3'd1;
					end else begin
						run.res[0].value_byte = "0";
						run.res[1] = '{IK_END, 8'h0, K_DEC, clip(start_row_q),
							clip(start_column_q), 1'b0};
						run.count = 3'd2;
						relex = 1'b1;
					end
				end
				ST_BIN, ST_OCT, ST_HEX, ST_DEC, ST_NAME, ST_OPER: begin
					logic keep;
					logic [3:0] tk;
					case (lex_state_q)
						ST_BIN:  begin keep = (b == "0" || b == "1" || b == "u"); tk = K_BIN; end
						ST_OCT:  begin keep = is_odig(b) || b == "u"; tk = K_OCT; end
						ST_HEX:  begin keep = is_hex(b) || b == "u"; tk = K_HEX; end
						ST_DEC:  begin
							keep = is_dig(b) || b == "u" || b == ".";
							tk = float_seen_q ? K_FLOAT : K_DEC;
							if (b == ".") n_float = 1'b1;
						end
						ST_NAME: begin keep = is_alpha(b) || is_dig(b) || b == "_"; tk = K_NAME; end
						default: begin keep = is_cop(b); tk = K_OPER; end
					endcase
					if (keep) begin
						run.res[0].value_byte = b;
						run.count = 3'd1;
					end else begin
						run.res[0] = '{IK_END, 8'h0, tk, clip(start_row_q),
							clip(start_column_q), 1'b0};
						run.count = 3'd1;
						relex = 1'b1;
					end
				end
				default: relex = 1'b1;
			endcase
		end

		// normal-state handling, also for a byte that ended a token
		if (relex) begin
			n_state = ST_NORMAL;
			if (b == "#") begin
				n_srow = n_row; n_scol = n_col; n_state = ST_COMMENT;
			end else if (b == 8'h22 || b == 8'h27) begin
				n_srow = n_row; n_scol = n_col;
				n_state = (b == 8'h22) ? ST_STRING : ST_CHAR;
				n_phase = ESC_NONE;
			end else if (b == "0") begin
				n_srow = n_row; n_scol = n_col; n_state = ST_RADIX;
			end else if (b == 8'h0D) begin
				n_col = '0;
			end else if (b == 8'h0A) begin
				n_col = '0;
				n_row = sat_inc(n_row);
			end else if (b > 8'h20) begin
				n_srow = n_row; n_scol = n_col;
				run.res[run.count] = '{IK_VALUE, b, K_OTHER, 16'h0, 16'h0, 1'b0};
				run.count = run.count + 1'b1;
				if (is_dig(b)) begin
					n_state = ST_DEC; n_float = 1'b0;
				end else if (is_alpha(b) || b == "_") begin
					n_state = ST_NAME;
				end else if (is_op(b)) begin
					n_state = ST_OPER;
				end else if (b == ".") begin
					n_dot = 1'b1;
				end else begin
					run.res[run.count] = '{IK_END, 8'h0, K_OTHER, clip(n_row), clip(n_col), 1'b0};
					run.count = run.count + 1'b1;
				end
			end
		end
		if (run.count != 3'd0) run.res[run.count - 1'b1].last_of_run = 1'b1;
	end

	// run register between front and queue
	assign in_ready = !run_valid_q || run_ready;
	assign run_valid = run_valid_q;
	assign run_data = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_state_q <= ST_NORMAL;
			float_seen_q <= 1'b0;
			dot_pending_q <= 1'b0;
			esc_stop_q <= 1'b0;
			escape_phase_q <= ESC_NONE;
			escape_accum_q <= 9'h0;
			cur_row_q <= POSITION_BITS'(1);
			cur_column_q <= '0;
			start_row_q <= '0;
			start_column_q <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				lex_state_q <= n_state;
				float_seen_q <= n_float;
				dot_pending_q <= n_dot;
				esc_stop_q <= n_stop;
				escape_phase_q <= n_phase;
				escape_accum_q <= n_accum;
				cur_row_q <= n_row;
				cur_column_q <= n_col;
				start_row_q <= n_srow;
				start_column_q <= n_scol;
				run_valid_q <= (run.count != 3'd0);
			end else if (run_ready) begin
				run_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) run_q <= run;
	end

`ifndef SYNTH
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> (run_data.count != 3'd0 && run_data.count <= 3'd6))
		else $error("bad run count");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> run_data.res[run_data.count - 1'b1].last_of_run)
		else $error("run without last mark");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid && $stable(run_data))
		else $error("run dropped under stall");
`endif

endmodule

// ===== hdl/sct_back.sv =====
// back: short queue of runs and a sequencer that sends one result per cycle while out_ready is high
`timescale 1ns / 1ps
module sct_back import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_valid,
	output logic      run_ready,
	input  run_t      run_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// two-entry queue
	run_t q_mem [2];
	logic wp_q, rp_q;
	logic [1:0] fill_q;
	logic [CNT_BITS-1:0] idx_q;

	logic push, pop, fire;
	run_t head;

	assign head = q_mem[rp_q];
	assign run_ready = (fill_q != 2'd2);
	assign push = run_valid && run_ready;
	assign out_valid = (fill_q != 2'd0);
	assign out_data = head.res[idx_q];
	assign fire = out_valid && out_ready;
	assign pop = fire && (idx_q == head.count - 1'b1);

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= run_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= 2'd0;
			idx_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) begin
				rp_q <= !rp_q;
				idx_q <= '0;
			end else if (fire) begin
				idx_q <= idx_q + 1'b1;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q < head.count)
		else $error("sequencer index past run");
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> out_data.last_of_run)
		else $error("run popped before last result");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2)
		else $error("queue overfilled");
`endif

endmodule

// ===== hdl/source_char_tokenizer_core.sv =====
// Streaming source tokenizer: one byte or end mark per input word.
// Input channel in_valid/in_ready carries in_data (in_byte, end_of_input).
// Output channel out_valid/out_ready carries out_data: value bytes and token
// end words (kind and start row/column), last_of_run marks the final word
// caused by one input word.
// The front lexes an input word into a run of up to six words, held in a
// run register; a two-run queue feeds the back sequencer, which sends one
// word per cycle while out_ready is high. An accepted word passes the run
// register and the queue before its first output. Words with one result
// go at one per cycle, given out_ready; others send their results in turn.
// Reset (arst_n low) puts the lexer in the normal state at row 1, column 0
// and empties the queue. When the receiver stalls, the queue fills and then
// in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module source_char_tokenizer_core import sct_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic run_valid, run_ready;
	run_t run_data;

	sct_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.run_valid(run_valid), .run_ready(run_ready), .run_data(run_data)
	);

	sct_back u_back (
		.clk(clk), .arst_n(arst_n),
		.run_valid(run_valid), .run_ready(run_ready), .run_data(run_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ===== dv/source_char_tokenizer_core_tb.sv =====
// testbench for the source tokenizer core: predicted token words checked against the outputs
`timescale 1ns / 1ps
module source_char_tokenizer_core_tb;
	import sct_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	// lexer model state and expected word queue
	class token_scoreboard;
		logic [3:0]  lstate;
		bit          flt, dotp, estop;
		logic [2:0]  ephase;
		logic [8:0]  eacc;
		int unsigned row, col, srow, scol;
		out_word_t   pending_words[$];
		int          errors;

		function void clear();
			lstate = ST_NORMAL; flt = 0; dotp = 0; estop = 0;
			ephase = ESC_NONE; eacc = 0;
			row = 1; col = 0; srow = 0; scol = 0;
			pending_words.delete();
			errors = 0;
		endfunction

		function int unsigned sat(int unsigned v);
			return (v >= 65535) ? 65535 : v + 1;
		endfunction

		function void push(bit k, logic [7:0] vb, logic [3:0] tk, int unsigned r, int unsigned c);
			out_word_t w;
			w.item_kind = k; w.value_byte = vb; w.token_kind = tk;
			w.token_row = r[15:0]; w.token_column = c[15:0]; w.last_of_run = 0;
			pending_words.push_back(w);
		endfunction

		function void val(logic [7:0] b);
			push(IK_VALUE, b, K_OTHER, 0, 0);
		endfunction

		function void tok_end(logic [3:0] tk);
			push(IK_END, 8'h0, tk, srow, scol);
		endfunction

		function bit dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
		function bit odig(logic [7:0] c); return c >= "0" && c <= "7"; endfunction
		function bit alpha(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction
		function int hexv(logic [7:0] c);
			if (dig(c)) return c - "0";
			if (c >= "a" && c <= "f") return c - "a" + 10;
			if (c >= "A" && c <= "F") return c - "A" + 10;
			return -1;
		endfunction
		function bit opc(logic [7:0] c);
			return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "&" ||
				c == "|" || c == "^" || c == "=" || c == "<" || c == ">" || c == "!" || c == "~";
		endfunction
		function bit copc(logic [7:0] c);
			return c == "+" || c == "-" || c == "&" || c == "|" || c == "^" || c == "=" ||
				c == "<" || c == ">";
		endfunction

		function void mark(); srow = row; scol = col; endfunction

		function void lex_fresh(logic [7:0] b);
			lstate = ST_NORMAL;
			if (b == "#") begin
				mark(); lstate = ST_COMMENT;
			end else if (b == "\"" || b == "'") begin
				mark(); lstate = (b == "\"") ? ST_STRING : ST_CHAR; ephase = ESC_NONE;
			end else if (b == "0") begin
				mark(); lstate = ST_RADIX;
			end else if (b == 8'h0D) begin
				col = 0;
			end else if (b == 8'h0A) begin
				col = 0; row = sat(row);
			end else if (b > 8'h20) begin
				mark();
				if (dig(b)) begin
					lstate = ST_DEC; flt = 0; val(b);
				end else if (alpha(b) || b == "_") begin
					lstate = ST_NAME; val(b);
				end else if (opc(b)) begin
					lstate = ST_OPER; val(b);
				end else begin
					val(b);
					if (b == ".") dotp = 1;
					else tok_end(K_OTHER);
				end
			end
		endfunction

		function void esc_done(logic [8:0] v);
			val(v[7:0]); ephase = ESC_NONE;
		endfunction

		function void esc_digit(logic [7:0] b, int radix);
			int d;
			d = (radix == 16) ? hexv(b) : (odig(b) ? b - "0" : -1);
			if (estop) return;
			if (d < 0) begin
				estop = 1; return;
			end
			eacc = (eacc * radix + d) & 9'h1FF;
		endfunction

		function void lex_esc(logic [7:0] b);
			case (ephase)
				ESC_FIRST: begin
					eacc = 0; estop = 0;
					case (b)
						"a": esc_done(9'h07);
						"b": esc_done(9'h08);
						"t": esc_done(9'h09);
						"n": esc_done(9'h0A);
						"v": esc_done(9'h0B);
						"f": esc_done(9'h0C);
						"r": esc_done(9'h0D);
						"x": ephase = ESC_HEX1;
						default: begin
							if (odig(b)) begin
								eacc = b - "0"; ephase = ESC_OCT2;
							end else esc_done({1'b0, b});
						end
					endcase
				end
				ESC_HEX1: begin esc_digit(b, 16); ephase = ESC_HEX2; end
				ESC_HEX2: begin esc_digit(b, 16); esc_done(eacc); end
				ESC_OCT2: begin esc_digit(b, 8); ephase = ESC_OCT3; end
				default: begin esc_digit(b, 8); esc_done(eacc); end
			endcase
		endfunction

		function void end_relex(logic [3:0] tk, logic [7:0] b);
			tok_end(tk); lex_fresh(b);
		endfunction

		function void lex_one(logic [7:0] b);
			col = sat(col);
			if (dotp) begin
				dotp = 0;
				if (dig(b)) begin
					lstate = ST_DEC; flt = 1; val(b);
				end else end_relex(K_OTHER, b);
				return;
			end
			case (lstate)
				ST_COMMENT: begin
					if (b == "#") lstate = ST_NORMAL;
					else if (b == 8'h0A) begin col = 0; row = sat(row); end
				end
				ST_STRING, ST_CHAR: begin
					if (ephase != ESC_NONE) lex_esc(b);
					else if (b == ((lstate == ST_STRING) ? "\"" : "'")) begin
						tok_end((lstate == ST_STRING) ? K_STRING : K_CHAR);
						lstate = ST_NORMAL;
					end else if (b == "\\") ephase = ESC_FIRST;
					else val(b);
				end
				ST_RADIX: begin
					if (b == "b" || b == "B") lstate = ST_BIN;
					else if (b == "x" || b == "X") lstate = ST_HEX;
					else if (b == ".") begin
						lstate = ST_DEC; flt = 1; val("0"); val(".");
					end else if (odig(b)) begin
						lstate = ST_OCT; val(b);
					end else begin
						val("0"); end_relex(K_DEC, b);
					end
				end
				ST_BIN: if (b == "0" || b == "1" || b == "u") val(b); else end_relex(K_BIN, b);
				ST_OCT: if (odig(b) || b == "u") val(b); else end_relex(K_OCT, b);
				ST_HEX: if (hexv(b) >= 0 || b == "u") val(b); else end_relex(K_HEX, b);
				ST_DEC: begin
					if (b == ".") begin
						flt = 1; val(b);
					end else if (dig(b) || b == "u") val(b);
					else end_relex(flt ? K_FLOAT : K_DEC, b);
				end
				ST_NAME: if (alpha(b) || dig(b) || b == "_") val(b); else end_relex(K_NAME, b);
				ST_OPER: if (copc(b)) val(b); else end_relex(K_OPER, b);
				default: lex_fresh(b);
			endcase
		endfunction

		function void lex_eoi();
			col = sat(col);
			if (dotp) tok_end(K_OTHER);
			else case (lstate)
				ST_COMMENT, ST_STRING, ST_CHAR: tok_end(K_ERROR);
				ST_RADIX: begin val("0"); tok_end(K_DEC); end
				ST_BIN: tok_end(K_BIN);
				ST_OCT: tok_end(K_OCT);
				ST_HEX: tok_end(K_HEX);
				ST_DEC: tok_end(flt ? K_FLOAT : K_DEC);
				ST_NAME: tok_end(K_NAME);
				ST_OPER: tok_end(K_OPER);
				default: ;
			endcase
			dotp = 0; lstate = ST_NORMAL; ephase = ESC_NONE; eacc = 0; estop = 0;
			push(IK_END, 8'h0, K_EOF, row, col);
		endfunction

		// predict the words one accepted input causes
		function void note_input(in_word_t w);
			int n;
			n = pending_words.size();
			if (w.end_of_input) lex_eoi();
			else lex_one(w.in_byte);
			if (pending_words.size() > n)
				pending_words[pending_words.size() - 1].last_of_run = 1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_word(out_word_t got);
			out_word_t e;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				return;
			end
			e = pending_words.pop_front();
			if (got.item_kind !== e.item_kind)
				report($sformatf("item_kind %h exp %h", got.item_kind, e.item_kind));
			if (got.value_byte !== e.value_byte)
				report($sformatf("value_byte %h exp %h", got.value_byte, e.value_byte));
			if (got.token_kind !== e.token_kind)
				report($sformatf("token_kind %0d exp %0d", got.token_kind, e.token_kind));
			if (got.token_row !== e.token_row)
				report($sformatf("token_row %0d exp %0d", got.token_row, e.token_row));
			if (got.token_column !== e.token_column)
				report($sformatf("token_column %0d exp %0d", got.token_column, e.token_column));
			if (got.last_of_run !== e.last_of_run)
				report($sformatf("last_of_run %b exp %b", got.last_of_run, e.last_of_run));
		endtask
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	in_word_t  in_data;
	out_word_t out_data;
	token_scoreboard sb;
	int src_idle_pct, snk_idle_pct;
	int quiet_cycles = 0;
	bit timed_out = 0;

	source_char_tokenizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// check output words and watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_word(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
				timed_out = 1;
				$display("watchdog expired");
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_word(logic [7:0] b, bit eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= '{in_byte: b, end_of_input: eoi};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input('{in_byte: b, end_of_input: eoi});
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_word(s[i], 0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_words.size() != 0);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// random source fragment, mostly well formed
	task automatic send_fragment();
		int n;
		n = $urandom_range(1, 5);
		case ($urandom_range(11))
			0: begin send_word("0", 0); send_word(pick("bB"), 0);
				repeat (n) send_word(pick("01u"), 0); end
			1: begin send_word("0", 0); send_word(pick("xX"), 0);
				repeat (n) send_word(pick("0123456789abcdefABCDEFu"), 0); end
			2: begin send_word("0", 0); repeat (n) send_word(pick("01234567u"), 0); end
			3: repeat (n) send_word(pick("0123456789.u"), 0);
			4: repeat (n) send_word(pick("_azAZ09qm"), 0);
			5: repeat (n) send_word(pick("+-*/%&|^=<>!~"), 0);
			6, 7: begin
				send_word(pick("\"'"), 0);
				repeat (n) begin
					if ($urandom_range(2) == 0) begin
						send_word("\\", 0);
						send_word(pick("abtnvfrx0178q\"'\\"), 0);
						if ($urandom_range(1)) begin
							send_word(pick("0123456789afAFgz"), 0);
							send_word(pick("0123456789afAFgz"), 0);
						end
					end else send_word(8'($urandom_range(255)), 0);
				end
				send_word(pick("\"'"), 0);
			end
			8: begin send_word("#", 0); repeat (n) send_word(8'($urandom_range(255)), 0);
				send_word("#", 0); end
			9: repeat (n) send_word(pick(" \t\r\n.;(),."), 0);
			10: send_word(8'($urandom_range(255)), 0);
			default: send_word(8'h0, 1);
		endcase
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		src_idle_pct = 6;
		snk_idle_pct = 76;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: numbers, names, operators, escapes, lone dot, unterminated constructs
		send_text("0b10u 0x1fF 017 0 0. 9.5u .5 . a_9 <<= ! ");
		send_text("\"\\a\\x4g\\101\\\"\\q\" '\\xff' ;");
		send_word(8'hFF, 0);
		send_word(8'h00, 1);
		send_text("\"ab");
		send_word(8'h00, 1);
		send_text("#c\n");
		send_word(8'h00, 1);
		send_text("0x");
		send_word(8'h00, 1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
			snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 6 : 0;
			for (int k = 0; k < 33; k++) send_fragment();
			drain();
		end
		send_word(8'h00, 1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
